// ===== hw/rtl/rdp_pkg.sv =====
// shared types and link character constants for the debug packet deframer
package rdp_pkg;

  // widths of the item and result fields
  localparam int unsigned LEN_W = 12;
  localparam int unsigned REP_W = 7;

  // link characters and decode constants
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BRACE  = 8'h7D;
  localparam logic [7:0] CH_CTRL_C = 8'h03;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] ESC_FLIP  = 8'h20;
  localparam logic [7:0] RUN_BIAS  = 8'd29;
  localparam logic [7:0] RUN_TOP   = 8'd126;
  localparam logic [REP_W-1:0] RUN_MAX = 7'd97;

  // configuration register indexes
  localparam logic CFG_NO_ACK  = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  // result kinds
  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_RESTART = 3'd1,
    KIND_OK      = 3'd2,
    KIND_BAD     = 3'd3,
    KIND_INTR    = 3'd4,
    KIND_OVFL    = 3'd5,
    KIND_DISC    = 3'd6
  } rdp_kind_t;

  // one request from the link
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_closed;
  } rdp_item_t;

  // one result
  typedef struct packed {
    rdp_kind_t        kind;
    logic [7:0]       data_byte;
    logic [REP_W-1:0] repeat_count;
    logic [LEN_W-1:0] length;
    logic             send_reply;
    logic [7:0]       reply_byte;
  } rdp_result_t;

endpackage

// ===== hw/rtl/rdp_dec.sv =====
// packet decode state and combinational next-state and result logic
module rdp_dec (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  rdp_pkg::rdp_item_t             item,
  input  logic                           no_ack,
  input  logic [rdp_pkg::LEN_W-1:0]      cap,
  output logic                           res_valid,
  output rdp_pkg::rdp_result_t           res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_ESC  = 3'd2,
    PH_RUN  = 3'd3,
    PH_CK1  = 3'd4,
    PH_CK2  = 3'd5
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [3:0]                 digit_r, digit_nxt;
  logic [rdp_pkg::LEN_W-1:0]  count_r, count_nxt;
  logic [7:0]                 prev_r, prev_nxt;

  logic [7:0]                 b;
  logic [7:0]                 sum_add;
  logic [4:0]                 hex;
  logic [rdp_pkg::REP_W-1:0]  rle_n;
  logic [7:0]                 run_byte;
  logic [rdp_pkg::REP_W-1:0]  run_n;
  logic [rdp_pkg::LEN_W-1:0]  rem;
  logic [rdp_pkg::REP_W-1:0]  copies;
  logic [rdp_pkg::LEN_W-1:0]  new_count;
  logic                       run_full;
  logic                       run_go;
  logic                       bad;
  logic                       go_idle;
  logic                       restart;

  // hex digit decode, bit 4 flags a valid digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b1, 4'(c - 8'h37)};
    end
    return v;
  endfunction

  assign b       = item.rx_byte;
  assign sum_add = sum_r + b;
  assign hex     = hex_value(b);

  // run length from the count byte, saturated
  assign rle_n = (b <= rdp_pkg::RUN_BIAS) ? '0 :
                 (b >= rdp_pkg::RUN_TOP)  ? rdp_pkg::RUN_MAX :
                 rdp_pkg::REP_W'(b - rdp_pkg::RUN_BIAS);

  // run source: repeat of the previous byte, escaped byte or plain byte
  assign run_byte = (phase_r == PH_RUN) ? prev_r :
                    (phase_r == PH_ESC) ? (b ^ rdp_pkg::ESC_FLIP) : b;
  assign run_n    = (phase_r == PH_RUN) ? rle_n : rdp_pkg::REP_W'(1);

  // clip the run to the room left
  assign rem       = (cap > count_r) ? (cap - count_r) : '0;
  assign copies    = (rdp_pkg::LEN_W'(run_n) < rem) ? run_n : rem[rdp_pkg::REP_W-1:0];
  assign new_count = count_r + rdp_pkg::LEN_W'(copies);
  assign run_full  = (new_count >= cap);

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    digit_nxt = digit_r;
    count_nxt = count_r;
    prev_nxt  = prev_r;
    res_valid = 1'b0;
    res       = '0;
    run_go    = 1'b0;
    bad       = 1'b0;
    go_idle   = 1'b0;
    restart   = 1'b0;

    if (item.link_closed) begin
      res_valid  = 1'b1;
      res.kind   = rdp_pkg::KIND_DISC;
      res.length = count_r;
      go_idle    = 1'b1;
    end else if (phase_r == PH_ESC) begin
      sum_nxt = sum_add;
      run_go  = 1'b1;
    end else if (phase_r == PH_RUN) begin
      if (b == rdp_pkg::CH_HASH || b == rdp_pkg::CH_DOLLAR ||
          b == rdp_pkg::CH_PLUS || b == rdp_pkg::CH_MINUS) begin
        bad = 1'b1;
      end else begin
        sum_nxt   = sum_add;
        phase_nxt = PH_CMD;
        run_go    = (rle_n != '0);
      end
    end else if (b == rdp_pkg::CH_DOLLAR) begin
      res_valid  = 1'b1;
      res.kind   = rdp_pkg::KIND_RESTART;
      res.length = count_r;
      go_idle    = 1'b1;
      restart    = 1'b1;
    end else if (b == rdp_pkg::CH_HASH) begin
      if (phase_r == PH_CMD) begin
        phase_nxt = PH_CK1;
      end else begin
        bad = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_CMD: begin
          sum_nxt = sum_add;
          if (b == rdp_pkg::CH_STAR) begin
            if (count_r == '0) begin
              bad = 1'b1;
            end else begin
              phase_nxt = PH_RUN;
            end
          end else if (b == rdp_pkg::CH_BRACE) begin
            phase_nxt = PH_ESC;
          end else begin
            run_go = 1'b1;
          end
        end
        PH_CK1: begin
          if (!hex[4]) begin
            bad = 1'b1;
          end else begin
            digit_nxt = hex[3:0];
            phase_nxt = PH_CK2;
          end
        end
        PH_CK2: begin
          if (hex[4] && {digit_r, hex[3:0]} == sum_r) begin
            res_valid      = 1'b1;
            res.kind       = rdp_pkg::KIND_OK;
            res.length     = count_r;
            res.send_reply = !no_ack;
            res.reply_byte = rdp_pkg::CH_PLUS;
            go_idle        = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (b == rdp_pkg::CH_CTRL_C) begin
            res_valid = 1'b1;
            res.kind  = rdp_pkg::KIND_INTR;
          end
        end
      endcase
    end

    // write one run of payload bytes
    if (run_go) begin
      prev_nxt         = run_byte;
      phase_nxt        = PH_CMD;
      count_nxt        = new_count;
      res_valid        = 1'b1;
      res.data_byte    = run_byte;
      res.repeat_count = copies;
      res.length       = new_count;
      if (run_full) begin
        res.kind = rdp_pkg::KIND_OVFL;
        go_idle  = 1'b1;
      end else begin
        res.kind = rdp_pkg::KIND_DATA;
      end
    end

    // malformed frame gets a nak
    if (bad) begin
      res_valid      = 1'b1;
      res.kind       = rdp_pkg::KIND_BAD;
      res.length     = count_r;
      res.send_reply = 1'b1;
      res.reply_byte = rdp_pkg::CH_MINUS;
      go_idle        = 1'b1;
    end

    // drop the frame state
    if (go_idle) begin
      phase_nxt = PH_IDLE;
      sum_nxt   = '0;
      digit_nxt = '0;
      count_nxt = '0;
    end
    if (restart) begin
      phase_nxt = PH_CMD;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sum_r   <= '0;
      digit_r <= '0;
      count_r <= '0;
      prev_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      digit_r <= digit_nxt;
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
    end
  end

`ifndef SYNTHESIS
  // a dropped link leaves an empty idle frame
  a_disc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.link_closed |=> phase_r == PH_IDLE && count_r == '0 && sum_r == '0)
    else $error("link drop did not clear the frame");

  // overflow ends the packet
  a_ovfl_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_valid && res.kind == rdp_pkg::KIND_OVFL |=> phase_r == PH_IDLE && count_r == '0)
    else $error("overflow did not end the packet");

  // a data run always carries copies and stays below capacity
  a_data_run: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == rdp_pkg::KIND_DATA |-> res.repeat_count != '0 && res.length < cap)
    else $error("bad data run");

  // a run is never started without a byte written before it
  a_run_prev: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RUN |-> count_r != '0)
    else $error("run with no preceding byte");
`endif

endmodule

// ===== hw/rtl/remote_debug_packet_deframer.sv =====
// top level of the debug packet deframer: input stage, config, result register
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid/in_ready   | in_rx_byte, in_link_closed
//  out     | out_valid/out_ready | out_kind, out_data_byte, out_repeat_count,
//          |                     | out_length, out_send_reply, out_reply_byte
//  cfg     | cfg_we (no wait)    | cfg_index, cfg_data
//
// one request per cycle sustained unless the result register stalls; a request is
// held in the input register, then decoded in one pass into the result register
// a stalled result register holds the decode stage, which then holds the input stage
// rst_n is synchronous, active low; no clearing pass, accepting from the first cycle
module remote_debug_packet_deframer #(
  parameter int unsigned MAX_PACKET = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_link_closed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [6:0]  out_repeat_count,
  output logic [11:0] out_length,
  output logic        out_send_reply,
  output logic [7:0]  out_reply_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int unsigned LEN_MAX   = (1 << rdp_pkg::LEN_W) - 1;
  localparam int unsigned CAP_LIMIT = (MAX_PACKET - 1 > LEN_MAX) ? LEN_MAX : MAX_PACKET - 1;

  logic                       no_ack_r;
  logic [rdp_pkg::LEN_W-1:0]  max_len_r;
  logic [rdp_pkg::LEN_W-1:0]  cap;

  logic                       in_v_r;
  rdp_pkg::rdp_item_t         item_r;

  logic                       out_v_r;
  rdp_pkg::rdp_result_t       res_r;

  logic                       res_valid;
  rdp_pkg::rdp_result_t       res;
  logic                       out_free;
  logic                       adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_ack_r  <= 1'b0;
      max_len_r <= rdp_pkg::LEN_W'(LEN_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdp_pkg::CFG_NO_ACK:  no_ack_r  <= cfg_data[0];
        rdp_pkg::CFG_MAX_LEN: max_len_r <= cfg_data;
      endcase
    end
  end

  // usable capacity, clamped to the packet buffer and at least one
  always_comb begin
    cap = (max_len_r > rdp_pkg::LEN_W'(CAP_LIMIT)) ? rdp_pkg::LEN_W'(CAP_LIMIT) : max_len_r;
    if (cap == '0) begin
      cap = rdp_pkg::LEN_W'(1);
    end
  end

  // pipeline control
  assign out_free = !out_v_r || out_ready;
  assign adv      = in_v_r && (!res_valid || out_free);
  assign in_ready = !in_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.rx_byte     <= in_rx_byte;
      item_r.link_closed <= in_link_closed;
    end
  end

  // decode stage
  rdp_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (item_r),
    .no_ack    (no_ack_r),
    .cap       (cap),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_kind         = res_r.kind;
  assign out_data_byte    = res_r.data_byte;
  assign out_repeat_count = res_r.repeat_count;
  assign out_length       = res_r.length;
  assign out_send_reply   = res_r.send_reply;
  assign out_reply_byte   = res_r.reply_byte;

endmodule
